### src/aabb_axis_collision_resolver_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the collision resolver
// Shared concurrent assertion forms used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef AABB_AXIS_COLLISION_RESOLVER_TOP_MACROS_SVH
`define AABB_AXIS_COLLISION_RESOLVER_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define ACR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ACR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Types, constants and helpers for the box collision resolver.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int MaxTilesDefault = 256;
  localparam logic signed [31:0] EpsQ16 = 32'sd66;
  localparam int InWidth  = 208;
  localparam int OutWidth = 208;

  // register indexes
  localparam logic [2:0] RegLoX    = 3'd0;
  localparam logic [2:0] RegLoY    = 3'd1;
  localparam logic [2:0] RegLoZ    = 3'd2;
  localparam logic [2:0] RegHiX    = 3'd3;
  localparam logic [2:0] RegHiY    = 3'd4;
  localparam logic [2:0] RegHiZ    = 3'd5;
  localparam logic [2:0] RegColors = 3'd6;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqMove = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_SCAN,
    ST_TEST,
    ST_APPLY,
    ST_DONE
  } state_t;

  // one tile entry as stored in memory
  typedef struct packed {
    logic        [2:0]  colors;
    logic signed [31:0] max_z;
    logic signed [31:0] max_y;
    logic signed [31:0] max_x;
    logic signed [31:0] min_z;
    logic signed [31:0] min_y;
    logic signed [31:0] min_x;
  } tile_t;

  localparam int TileWidth = $bits(tile_t);

  // saturating 32-bit signed add
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF)      sat_add = 32'sh7FFF_FFFF;
    else if (s < -33'sh0_8000_0000) sat_add = 32'sh8000_0000;
    else                           sat_add = s[31:0];
  endfunction

  // saturating 32-bit signed subtract
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s > 33'sh0_7FFF_FFFF)      sat_sub = 32'sh7FFF_FFFF;
    else if (s < -33'sh0_8000_0000) sat_sub = 32'sh8000_0000;
    else                           sat_sub = s[31:0];
  endfunction

endpackage

### src/acr_ram.sv
// ----------------------------------------------------------------------------
// acr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module acr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/acr_solid_bits.sv
// ----------------------------------------------------------------------------
// acr_solid_bits
// Per-entry solid flags, cleared by reset, with registered read.
// ----------------------------------------------------------------------------
module acr_solid_bits #(
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic                     rdata
);

  logic [Depth-1:0] solid_r;

  // flags and read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r <= '0;
      rdata   <= 1'b0;
    end else begin
      if (we) begin
        solid_r[waddr] <= wdata;
      end
      rdata <= solid_r[raddr];
    end
  end

endmodule

### src/acr_seq.sv
// ----------------------------------------------------------------------------
// acr_seq
// Sequencer and shared saturating adder for per-axis resolution.
// ----------------------------------------------------------------------------
module acr_seq #(
  parameter int MaxTiles = acr_pkg::MaxTilesDefault
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [31:0]               pos_in [3],
  input  logic signed [31:0]               push_in [3],
  input  logic signed [31:0]               lo_off [3],
  input  logic signed [31:0]               hi_off [3],
  input  logic [2:0]                       lvl_colors,
  output logic [$clog2(MaxTiles)-1:0]      raddr,
  input  acr_pkg::tile_t                   tile,
  input  logic                             tile_solid,
  output logic                             busy,
  output logic                             done,
  output logic signed [31:0]               pos_out [3],
  output logic signed [31:0]               corr_out [3],
  output logic [2:0]                       hit_out,
  output logic                             below_valid,
  output logic [7:0]                       below_index
);

  localparam int AW = $clog2(MaxTiles);
  localparam int CW = $clog2(MaxTiles + 1);

  acr_pkg::state_t state_r, state_nxt;
  logic [1:0]          axis_r, axis_nxt;
  logic [1:0]          sub_r, sub_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic signed [31:0]  pos_r [3];
  logic signed [31:0]  push_r [3];
  logic signed [31:0]  corr_r [3];
  logic signed [31:0]  blo_r [3];
  logic signed [31:0]  bhi_r [3];
  logic signed [31:0]  back_r, fwd_r;
  logic [AW-1:0]       fidx_r;
  logic                fval_r, hit_r;
  logic [2:0]          hmask_r;
  logic                bval_r;
  logic [7:0]          bidx_r;
  logic [1:0]          aidx;
  logic                ovl;
  logic signed [31:0]  tmin [3];
  logic signed [31:0]  tmax [3];
  logic signed [31:0]  add_a, add_b, add_y;
  logic signed [31:0]  back_c, fwd_c;

  assign tmin[0] = tile.min_x; assign tmin[1] = tile.min_y; assign tmin[2] = tile.min_z;
  assign tmax[0] = tile.max_x; assign tmax[1] = tile.max_y; assign tmax[2] = tile.max_z;

  // shared saturating adder
  assign add_y = acr_pkg::sat_add(add_a, add_b);
  assign aidx  = axis_r;
  assign raddr = idx_r[AW-1:0];

  // overlap test against precomputed agent box
  always_comb begin
    ovl = tile_solid && ((tile.colors & lvl_colors) != 3'd0);
    for (int k = 0; k < 3; k++) begin
      if (bhi_r[k] < tmin[k] || blo_r[k] > tmax[k]) ovl = 1'b0;
    end
    back_c = acr_pkg::sat_sub(tmin[aidx], bhi_r[aidx]);
    fwd_c  = acr_pkg::sat_sub(tmax[aidx], blo_r[aidx]);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
      sub_r  <= '0;
      idx_r  <= '0;
    end else begin
      axis_r <= axis_nxt;
      sub_r  <= sub_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // next state and adder operand select
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    sub_nxt   = sub_r;
    idx_nxt   = idx_r;
    add_a     = pos_r[aidx];
    add_b     = push_r[aidx];
    unique case (state_r)
      acr_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = acr_pkg::ST_AXIS;
          axis_nxt  = 2'd0;
          sub_nxt   = 2'd0;
        end
      end
      acr_pkg::ST_AXIS: begin
        // sub 0: pos += push; sub 1..3 unused box pass via ST_SCAN
        add_a     = pos_r[aidx];
        add_b     = push_r[aidx];
        state_nxt = acr_pkg::ST_SCAN;
        sub_nxt   = 2'd0;
      end
      acr_pkg::ST_SCAN: begin
        // recompute agent box: lo through the shared adder and hi, one axis per sub
        add_a = pos_r[sub_r];
        add_b = lo_off[sub_r];
        if (sub_r == 2'd2) begin
          state_nxt = acr_pkg::ST_TEST;
          idx_nxt   = '0;
        end
        sub_nxt = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
      end
      acr_pkg::ST_TEST: begin
        // idx 0 issues the first read; its data is valid in the next cycle
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(MaxTiles)) begin
          state_nxt = acr_pkg::ST_APPLY;
        end
      end
      acr_pkg::ST_APPLY: begin
        add_a = back_r;
        add_b = -acr_pkg::EpsQ16;
        if (push_r[aidx][31]) add_a = fwd_r;
        if (push_r[aidx][31]) add_b = acr_pkg::EpsQ16;
        if (sub_r == 2'd1) begin
          add_a = pos_r[aidx];
          add_b = corr_r[aidx];
          sub_nxt = 2'd0;
          if (axis_r == 2'd2) begin
            state_nxt = acr_pkg::ST_DONE;
          end else begin
            state_nxt = acr_pkg::ST_AXIS;
            axis_nxt  = axis_r + 2'd1;
          end
        end else begin
          sub_nxt = 2'd1;
        end
      end
      acr_pkg::ST_DONE: begin
        state_nxt = acr_pkg::ST_IDLE;
      end
      default: state_nxt = acr_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == acr_pkg::ST_IDLE && start) begin
      for (int k = 0; k < 3; k++) begin
        pos_r[k]  <= pos_in[k];
        push_r[k] <= push_in[k];
        corr_r[k] <= '0;
      end
      hmask_r <= '0;
      bval_r  <= 1'b0;
      bidx_r  <= '0;
    end
    if (state_r == acr_pkg::ST_AXIS) begin
      pos_r[aidx] <= add_y;
      back_r <= '0;
      fwd_r  <= '0;
      fval_r <= 1'b0;
      hit_r  <= 1'b0;
    end
    if (state_r == acr_pkg::ST_SCAN) begin
      blo_r[sub_r] <= add_y;
      bhi_r[sub_r] <= acr_pkg::sat_add(pos_r[sub_r], hi_off[sub_r]);
    end
    if (state_r == acr_pkg::ST_TEST && idx_r != '0 && ovl) begin
      if (back_c < back_r) back_r <= back_c;
      if (fwd_c > fwd_r) begin
        fwd_r  <= fwd_c;
        fidx_r <= AW'(idx_r - CW'(1));
        fval_r <= 1'b1;
      end
      hit_r <= 1'b1;
    end
    if (state_r == acr_pkg::ST_APPLY && hit_r) begin
      if (sub_r == 2'd0) begin
        hmask_r[aidx] <= 1'b1;
        if (push_r[aidx] != '0) corr_r[aidx] <= add_y;
        if (aidx == 2'd1 && push_r[aidx][31]) begin
          bval_r <= fval_r;
          bidx_r <= fval_r ? 8'(fidx_r) : 8'd0;
        end
      end else if (push_r[aidx] != '0) begin
        pos_r[aidx] <= add_y;
      end
    end
  end

  assign busy        = state_r != acr_pkg::ST_IDLE;
  assign done        = state_r == acr_pkg::ST_DONE;
  assign pos_out     = pos_r;
  assign corr_out    = corr_r;
  assign hit_out     = hmask_r;
  assign below_valid = bval_r;
  assign below_index = bidx_r;

  `include "aabb_axis_collision_resolver_top_macros.svh"

  `ACR_ASSERT_NXT(a_start_leaves_idle, clk, rst_n, state_r == acr_pkg::ST_IDLE && start, state_r == acr_pkg::ST_AXIS)
  `ACR_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == acr_pkg::ST_TEST, idx_r <= CW'(MaxTiles))
  `ACR_ASSERT_NXT(a_done_once, clk, rst_n, state_r == acr_pkg::ST_DONE, state_r == acr_pkg::ST_IDLE)

endmodule

### src/aabb_axis_collision_resolver_top.sv
// ----------------------------------------------------------------------------
// aabb_axis_collision_resolver_top
// Per-axis box collision resolution against a loaded tile table.
// ----------------------------------------------------------------------------
// A load beat writes the table at its accepting edge and returns one all-zero
// result beat on the next cycle. A move beat returns its result beat after
// all three axes are resolved, with the table sized to MAX_TILES rounded up
// to a power of two. Each axis scans every table entry once through one
// registered memory read port and a shared saturating adder. The block is
// not ready while a move runs or while a result beat waits on out_tready, so
// the next request can be taken the cycle after the result beat leaves.
module aabb_axis_collision_resolver_top #(
  parameter int MAX_TILES = acr_pkg::MaxTilesDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, low to high: tile_index[7:0], first_x, first_y, first_z,
  // second_x, second_y, second_z, tile_colors[2:0], tile_solid, zero pad
  input  logic [207:0] in_tdata,
  // tuser: req_type
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata, low to high: new_x, new_y, new_z, correction_x, correction_y,
  // correction_z, hit_mask[2:0], below_valid, below_index[7:0], zero pad
  output logic [207:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int DP = 1 << AW;

  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic [2:0]         colors_r;
  logic               ovalid_r;
  logic [207:0]       odata_r;

  logic               seq_busy, seq_done, start, load;
  logic [AW-1:0]      raddr;
  acr_pkg::tile_t     tile_w, tile_r;
  logic               solid_r;
  logic signed [31:0] pos_in [3];
  logic signed [31:0] push_in [3];
  logic signed [31:0] pos_o [3];
  logic signed [31:0] corr_o [3];
  logic [2:0]         hit_o;
  logic               bval_o;
  logic [7:0]         bidx_o;
  logic [7:0]         tidx;
  logic               wr_ok;

  assign cfg_ready = 1'b1;
  assign in_tready = !seq_busy && !ovalid_r;

  assign tidx  = in_tdata[7:0];
  assign wr_ok = (32'(tidx) < 32'(MAX_TILES));
  assign load  = in_tvalid && in_tready && (in_tuser == acr_pkg::ReqLoad);
  assign start = in_tvalid && in_tready && (in_tuser == acr_pkg::ReqMove);

  assign tile_w.min_x  = in_tdata[39:8];
  assign tile_w.min_y  = in_tdata[71:40];
  assign tile_w.min_z  = in_tdata[103:72];
  assign tile_w.max_x  = in_tdata[135:104];
  assign tile_w.max_y  = in_tdata[167:136];
  assign tile_w.max_z  = in_tdata[199:168];
  assign tile_w.colors = in_tdata[202:200];

  assign pos_in[0]  = in_tdata[39:8];
  assign pos_in[1]  = in_tdata[71:40];
  assign pos_in[2]  = in_tdata[103:72];
  assign push_in[0] = in_tdata[135:104];
  assign push_in[1] = in_tdata[167:136];
  assign push_in[2] = in_tdata[199:168];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= -32'sd32768;
        hi_r[k] <= 32'sd32768;
      end
      colors_r <= 3'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acr_pkg::RegLoX:    lo_r[0]  <= cfg_data;
        acr_pkg::RegLoY:    lo_r[1]  <= cfg_data;
        acr_pkg::RegLoZ:    lo_r[2]  <= cfg_data;
        acr_pkg::RegHiX:    hi_r[0]  <= cfg_data;
        acr_pkg::RegHiY:    hi_r[1]  <= cfg_data;
        acr_pkg::RegHiZ:    hi_r[2]  <= cfg_data;
        acr_pkg::RegColors: colors_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // tile table
  acr_ram #(.Width(acr_pkg::TileWidth), .Depth(DP)) u_tiles (
    .clk   (clk),
    .we    (load && wr_ok),
    .waddr (AW'(tidx)),
    .wdata (tile_w),
    .raddr (raddr),
    .rdata (tile_r)
  );

  acr_solid_bits #(.Depth(DP)) u_solid (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (load && wr_ok),
    .waddr (AW'(tidx)),
    .wdata (in_tdata[203]),
    .raddr (raddr),
    .rdata (solid_r)
  );

  acr_seq #(.MaxTiles(DP)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .pos_in      (pos_in),
    .push_in     (push_in),
    .lo_off      (lo_r),
    .hi_off      (hi_r),
    .lvl_colors  (colors_r),
    .raddr       (raddr),
    .tile        (tile_r),
    .tile_solid  (solid_r),
    .busy        (seq_busy),
    .done        (seq_done),
    .pos_out     (pos_o),
    .corr_out    (corr_o),
    .hit_out     (hit_o),
    .below_valid (bval_o),
    .below_index (bidx_o)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (load || seq_done) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      odata_r <= '0;
    end else if (seq_done) begin
      odata_r <= {4'd0, bidx_o, bval_o, hit_o, corr_o[2], corr_o[1], corr_o[0],
                  pos_o[2], pos_o[1], pos_o[0]};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  `include "aabb_axis_collision_resolver_top_macros.svh"

  `ACR_ASSERT_IMP(a_no_accept_busy, clk, rst_n, seq_busy, !in_tready)
  `ACR_ASSERT_IMP(a_done_slot_free, clk, rst_n, seq_done, !ovalid_r)
  `ACR_ASSERT_NXT(a_load_gives_beat, clk, rst_n, load, out_tvalid)

endmodule

### tb/acr_collision_checker.sv
// ----------------------------------------------------------------------------
// acr_collision_checker
// Watches the config, request and result channels of the collision resolver,
// keeps its own copy of the tile table and agent registers, works out the
// result of every accepted request and compares each result beat field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module acr_collision_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [207:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [207:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);

  localparam int NumTiles = 256;
  localparam logic signed [31:0] Margin = acr_pkg::EpsQ16;

  // shadow registers
  logic signed [31:0] off_lo [3];
  logic signed [31:0] off_hi [3];
  logic [2:0]         color_mask;

  // shadow tile table
  logic signed [31:0] tile_min [3][NumTiles];
  logic signed [31:0] tile_max [3][NumTiles];
  logic [2:0]         tile_col [NumTiles];
  logic               tile_solid [NumTiles];

  logic [207:0] result_q [$];

  initial errors = 0;
  assign pending = result_q.size();

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // full per-axis resolution of one move beat
  function automatic logic [207:0] resolve_move(input logic [207:0] d);
    logic signed [31:0] p [3];
    logic signed [31:0] push [3];
    logic signed [31:0] corr [3];
    logic signed [31:0] lo, hi, a0, a1, back, fwd, best_back, best_fwd;
    logic [2:0] hits;
    logic       bv, ov, fv, hit;
    logic [7:0] bi, fi;
    hits = '0; bv = 1'b0; bi = '0;
    for (int k = 0; k < 3; k++) begin
      p[k]    = d[8 + 32*k +: 32];
      push[k] = d[104 + 32*k +: 32];
      corr[k] = '0;
    end
    for (int ax = 0; ax < 3; ax++) begin
      best_back = '0; best_fwd = '0; fv = 1'b0; hit = 1'b0; fi = '0;
      p[ax] = clamp32(longint'(p[ax]) + longint'(push[ax]));
      for (int t = 0; t < NumTiles; t++) begin
        if (!tile_solid[t] || (tile_col[t] & color_mask) == 3'd0) continue;
        ov = 1'b1; a0 = '0; a1 = '0;
        for (int k = 0; k < 3; k++) begin
          lo = clamp32(longint'(p[k]) + longint'(off_lo[k]));
          hi = clamp32(longint'(p[k]) + longint'(off_hi[k]));
          if (hi < tile_min[k][t] || lo > tile_max[k][t]) begin
            ov = 1'b0;
            break;
          end
          if (k == ax) begin
            a0 = lo;
            a1 = hi;
          end
        end
        if (!ov) continue;
        back = clamp32(longint'(tile_min[ax][t]) - longint'(a1));
        fwd  = clamp32(longint'(tile_max[ax][t]) - longint'(a0));
        if (back < best_back) best_back = back;
        // strictly larger, so the lowest index wins a tie
        if (fwd > best_fwd) begin
          best_fwd = fwd;
          fi = t[7:0];
          fv = 1'b1;
        end
        hit = 1'b1;
      end
      if (hit) begin
        hits[ax] = 1'b1;
        if (push[ax] > 0) begin
          corr[ax] = clamp32(longint'(best_back) - longint'(Margin));
          p[ax]    = clamp32(longint'(p[ax]) + longint'(corr[ax]));
        end else if (push[ax] < 0) begin
          corr[ax] = clamp32(longint'(best_fwd) + longint'(Margin));
          p[ax]    = clamp32(longint'(p[ax]) + longint'(corr[ax]));
          if (ax == 1) begin
            bv = fv;
            bi = fv ? fi : 8'd0;
          end
        end
      end
    end
    return {4'b0, bi, bv, hits, corr[2], corr[1], corr[0], p[2], p[1], p[0]};
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  // compare one result beat with its prediction
  task automatic check_beat(input logic [207:0] got, input logic [207:0] want);
    string names [6];
    names = '{"new_x", "new_y", "new_z", "correction_x", "correction_y",
              "correction_z"};
    for (int k = 0; k < 6; k++)
      if (got[32*k +: 32] !== want[32*k +: 32])
        report_mismatch(names[k], got[32*k +: 32], want[32*k +: 32]);
    if (got[194:192] !== want[194:192])
      report_mismatch("hit_mask", 32'(got[194:192]), 32'(want[194:192]));
    if (got[195] !== want[195])
      report_mismatch("below_valid", 32'(got[195]), 32'(want[195]));
    if (got[203:196] !== want[203:196])
      report_mismatch("below_index", 32'(got[203:196]), 32'(want[203:196]));
    if (got[207:204] !== want[207:204])
      report_mismatch("pad", 32'(got[207:204]), 32'(want[207:204]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        off_lo[k] = -32'sd32768;
        off_hi[k] = 32'sd32768;
      end
      color_mask = 3'd7;
      for (int t = 0; t < NumTiles; t++) tile_solid[t] = 1'b0;
      result_q.delete();
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          acr_pkg::RegLoX:    off_lo[0] = cfg_data;
          acr_pkg::RegLoY:    off_lo[1] = cfg_data;
          acr_pkg::RegLoZ:    off_lo[2] = cfg_data;
          acr_pkg::RegHiX:    off_hi[0] = cfg_data;
          acr_pkg::RegHiY:    off_hi[1] = cfg_data;
          acr_pkg::RegHiZ:    off_hi[2] = cfg_data;
          acr_pkg::RegColors: color_mask = cfg_data[2:0];
          default: ;
        endcase
      end
      // request beat: loads update the table and return zeros
      if (in_tvalid && in_tready) begin
        if (in_tuser == acr_pkg::ReqLoad) begin
          for (int k = 0; k < 3; k++) begin
            tile_min[k][in_tdata[7:0]] = in_tdata[8 + 32*k +: 32];
            tile_max[k][in_tdata[7:0]] = in_tdata[104 + 32*k +: 32];
          end
          tile_col[in_tdata[7:0]]   = in_tdata[202:200];
          tile_solid[in_tdata[7:0]] = in_tdata[203];
          result_q.push_back('0);
        end else begin
          result_q.push_back(resolve_move(in_tdata));
        end
      end
      // result beat
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", 32'd1, 32'd0);
        end else begin
          check_beat(out_tdata, result_q.pop_front());
        end
      end
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the box collision resolver: directed tile and move
// beats at the edges of the ranges, then random tile scenes and moves under
// several agent box and color settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int Unit       = 65536;
  localparam int PhaseItems = 125;
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 2500;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [207:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           errors;
  int           pending;
  bit           calm = 1'b0;
  bit           hold_rx = 1'b0;
  int           idle_cycles = 0;

  aabb_axis_collision_resolver_top dut (.*);

  acr_collision_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 6) != 0) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // result side: random ready with one long hold-off on request
  initial begin
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic logic [207:0] pack_beat(
    input logic [7:0] idx,
    input int ax, input int ay, input int az,
    input int bx, input int by, input int bz,
    input logic [2:0] col, input logic sol);
    return {4'b0, sol, col, bz, by, bx, az, ay, ax, idx};
  endfunction

  task automatic send_beat(input logic kind, input logic [207:0] d);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_setup(input int lo_v, input int hi_v, input logic [2:0] col);
    write_reg(acr_pkg::RegLoX, lo_v);
    write_reg(acr_pkg::RegLoY, lo_v);
    write_reg(acr_pkg::RegLoZ, lo_v);
    write_reg(acr_pkg::RegHiX, hi_v);
    write_reg(acr_pkg::RegHiY, hi_v);
    write_reg(acr_pkg::RegHiZ, hi_v);
    write_reg(acr_pkg::RegColors, 32'(col));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let every result drain, then allow the block to settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int near_coord();
    return int'($urandom_range(0, 16 * Unit)) - 8 * Unit;
  endfunction

  function automatic int small_push();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return int'($urandom_range(1, Unit));
      default: return -int'($urandom_range(1, Unit));
    endcase
  endfunction

  // one random beat: scene tiles, moves near them, and full-range noise
  task automatic random_beat();
    int lx, ly, lz;
    if ($urandom_range(0, 9) == 0) begin
      send_beat(logic'($urandom_range(0, 1)),
                pack_beat(8'($urandom), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, 3'($urandom), 1'($urandom)));
    end else if ($urandom_range(0, 99) < 35) begin
      lx = near_coord(); ly = near_coord(); lz = near_coord();
      if ($urandom_range(0, 9) == 0)
        send_beat(acr_pkg::ReqLoad, pack_beat(8'($urandom), lx, ly, lz, lx - Unit,
                                              ly - Unit, lz - Unit, 3'($urandom),
                                              1'b1));
      else
        send_beat(acr_pkg::ReqLoad, pack_beat(8'($urandom), lx, ly, lz,
                  lx + int'($urandom_range(Unit / 4, 3 * Unit)),
                  ly + int'($urandom_range(Unit / 4, 3 * Unit)),
                  lz + int'($urandom_range(Unit / 4, 3 * Unit)),
                  3'($urandom), $urandom_range(0, 7) != 0));
    end else begin
      send_beat(acr_pkg::ReqMove, pack_beat(8'($urandom), near_coord(), near_coord(),
                near_coord(), small_push(), small_push(), small_push(),
                3'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_setup(-Unit / 2, Unit / 2, 3'd7);

    // directed: a tile covering everything, saturation, edges, floors
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd7, 1'b1));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 0, 0, 0, Unit, 0, 0, 3'd0, 1'b0));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 0, 0, 0, 0, -Unit, 0, 3'd0, 1'b0));
    send_beat(acr_pkg::ReqMove, pack_beat(8'hFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd7, 1'b1));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd0, 1'b0));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd0, -Unit, -Unit, -Unit, Unit, Unit, Unit,
              3'd7, 1'b0));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd255, Unit, Unit, Unit, -Unit, -Unit,
              -Unit, 3'd7, 1'b1));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd1, -Unit, -Unit, -Unit, Unit, Unit, Unit,
              3'd2, 1'b1));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd2, -Unit, -2 * Unit, -Unit, Unit,
              -Unit / 4, Unit, 3'd4, 1'b1));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 0, 0, 0, 0, -Unit / 4, 0, 3'd0, 1'b0));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 0, 0, 0, Unit / 2, 0, -Unit / 2,
              3'd0, 1'b0));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd3, -Unit, -Unit, -Unit, Unit, Unit, Unit,
              3'd0, 1'b1));
    // tile touching the agent box edge exactly, inclusive overlap
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd4, Unit / 2, -Unit, -Unit, 2 * Unit,
              Unit, Unit, 3'd1, 1'b1));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 0, 0, 0, 0, 0, 0, 3'd0, 1'b0));
    send_beat(acr_pkg::ReqMove, pack_beat(8'd0, 5 * Unit, 5 * Unit, 5 * Unit, 0, 0, 0,
              3'd0, 1'b0));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd1, 0, 0, 0, 0, 0, 0, 3'd0, 1'b0));
    send_beat(acr_pkg::ReqLoad, pack_beat(8'd2, 0, 0, 0, 0, 0, 0, 3'd0, 1'b0));
    drain();

    // random phases over several agent box and color settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_setup(-Unit / 2, Unit / 2, 3'd7);
        1: write_setup(-Unit, Unit, 3'd1);
        2: write_setup(32'h8000_0000, 32'h7FFF_FFFF, 3'd0);
        3: write_setup(-int'($urandom_range(0, 2 * Unit)),
                       int'($urandom_range(0, 2 * Unit)), 3'($urandom));
        4: write_setup(Unit, -Unit, 3'd6);
        default: write_setup(32'h8000_0000, 32'h7FFF_FFFF, 3'd7);
      endcase
      calm    = (ph == 3);
      hold_rx = (ph == 1);
      for (int n = 0; n < PhaseItems; n++) random_beat();
      drain();
    end

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
